// ===== rtl/vbdma_pkg.sv =====
// ----------------------------------------------------------------------------
// vbdma_pkg
// Shared types and constants for the VRAM block DMA controller.
// ----------------------------------------------------------------------------
package vbdma_pkg;

    // Size of video memory in bytes (1024 .. 16384)
    localparam int VRAM_BYTES = 8192;

    localparam int          BLOCK_SHIFT  = 4;   // 16-byte blocks
    localparam int          STALL_SHIFT  = 5;   // 32 dots per block
    localparam logic [16:0] VRAM_END     = 17'(VRAM_BYTES);
    localparam logic [16:0] BLOCK_BYTES  = 17'd16;
    localparam logic [7:0]  LEN_MASK     = 8'h7F;
    localparam logic [7:0]  STATUS_IDLE  = 8'h80;

    typedef enum logic [2:0] {
        ACT_CONTROL  = 3'd0,
        ACT_STATUS   = 3'd1,
        ACT_HBLANK   = 3'd2,
        ACT_LOAD_SRC = 3'd3,
        ACT_LOAD_DST = 3'd4
    } t_action;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] copy_source;
        logic [13:0] copy_dest;
        logic [7:0]  copy_blocks;
        logic [12:0] stall_dots;
        logic        active_now;
    } t_result;

endpackage

// ===== rtl/vbdma_core.sv =====
// ----------------------------------------------------------------------------
// vbdma_core
// Transfer state (source, destination, length, armed) and the single-pass
// logic that executes one item and forms its result.
// ----------------------------------------------------------------------------
module vbdma_core import vbdma_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_write_value,
    input  logic [15:0] i_address_value,
    input  logic        i_cpu_halted,
    output t_result     o_result
);

    logic [15:0] r_src, n_src;
    logic [15:0] r_dst, n_dst;
    logic [11:0] r_bytes_left, n_bytes_left;
    logic        r_armed, n_armed;

    logic        w_fits;
    logic [16:0] w_room_bytes;
    logic [12:0] w_room_blocks;
    logic [7:0]  w_want;
    logic [7:0]  w_gen_blocks;
    logic [7:0]  w_blocks;
    logic [7:0]  w_status_rem;

    // room left before the end of video memory
    assign w_fits        = ({1'b0, r_dst} + BLOCK_BYTES) <= VRAM_END;
    assign w_room_bytes  = VRAM_END - {1'b0, r_dst};
    assign w_room_blocks = w_room_bytes[16:BLOCK_SHIFT];
    assign w_want        = (i_write_value & LEN_MASK) + 8'd1;

    always_comb begin
        if (!w_fits) begin
            w_gen_blocks = 8'd0;
        end else if ({5'd0, w_want} < w_room_blocks) begin
            w_gen_blocks = w_want;
        end else begin
            w_gen_blocks = w_room_blocks[7:0];  // at most want, so at most 128
        end
    end

    always_comb begin
        n_src        = r_src;
        n_dst        = r_dst;
        n_bytes_left = r_bytes_left;
        n_armed      = r_armed;
        w_blocks     = 8'd0;
        case (i_action)
            ACT_CONTROL: begin
                if (r_armed && !i_write_value[7]) begin
                    n_armed = 1'b0;             // cancel
                end else if (i_write_value[7]) begin
                    n_bytes_left = {w_want, 4'd0};
                    n_armed      = 1'b1;
                end else begin
                    // general burst runs at once
                    w_blocks     = w_gen_blocks;
                    n_src        = r_src + {4'd0, w_gen_blocks, 4'd0};
                    n_dst        = r_dst + {4'd0, w_gen_blocks, 4'd0};
                    n_bytes_left = {w_want - w_gen_blocks, 4'd0};
                    n_armed      = 1'b0;
                end
            end
            ACT_HBLANK: begin
                if (r_armed && !i_cpu_halted) begin
                    if (!w_fits) begin
                        n_armed = 1'b0;
                    end else begin
                        w_blocks     = 8'd1;
                        n_src        = r_src + BLOCK_BYTES[15:0];
                        n_dst        = r_dst + BLOCK_BYTES[15:0];
                        n_bytes_left = r_bytes_left - BLOCK_BYTES[11:0];
                        n_armed      = (r_bytes_left != BLOCK_BYTES[11:0]);
                    end
                end
            end
            ACT_LOAD_SRC: n_src = i_address_value;
            ACT_LOAD_DST: n_dst = i_address_value;
            default: ;
        endcase
    end

    assign w_status_rem = (n_bytes_left[11:BLOCK_SHIFT] - 8'd1) & LEN_MASK;

    always_comb begin
        o_result.read_data   = (n_armed ? 8'd0 : STATUS_IDLE) | w_status_rem;
        o_result.copy_source = (w_blocks != 8'd0) ? r_src : 16'd0;
        o_result.copy_dest   = (w_blocks != 8'd0) ? r_dst[13:0] : 14'd0;
        o_result.copy_blocks = w_blocks;
        o_result.stall_dots  = {w_blocks, 5'd0};
        o_result.active_now  = n_armed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src        <= '0;
            r_dst        <= '0;
            r_bytes_left <= '0;
            r_armed      <= 1'b0;
        end else if (i_fire) begin
            r_src        <= n_src;
            r_dst        <= n_dst;
            r_bytes_left <= n_bytes_left;
            r_armed      <= n_armed;
        end
    end

endmodule

// ===== rtl/vram_block_dma_controller.sv =====
// An item accepted into the input register is loaded into the result register
// when the result register is free; a stalled result holds it in the input register.
// Throughput: one item per cycle while neither side stalls; the transfer state is updated by the
// single-pass logic in the cycle an item leaves the input register.
// Reset (synchronous, active low) empties both registers and clears the
// source, destination, length and armed flag.
// ----------------------------------------------------------------------------
// vram_block_dma_controller
// 16-byte-block VRAM DMA engine: input register, execute logic, result
// register with independent stall on each side.
// ----------------------------------------------------------------------------
module vram_block_dma_controller import vbdma_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_write_value,
    input  logic [15:0] i_address_value,
    input  logic        i_cpu_halted,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_data,
    output logic [15:0] o_copy_source,
    output logic [13:0] o_copy_dest,
    output logic [7:0]  o_copy_blocks,
    output logic [12:0] o_stall_dots,
    output logic        o_active_now
);

    logic        r_s1_valid;
    logic [2:0]  r_action;
    logic [7:0]  r_write_value;
    logic [15:0] r_address_value;
    logic        r_cpu_halted;
    logic        r_out_valid;
    t_result     r_out;
    t_result     w_result;
    logic        w_out_free;
    logic        w_fire;
    logic        w_accept;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_fire     = r_s1_valid && w_out_free;
    assign o_stall    = r_s1_valid && !w_out_free;
    assign w_accept   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action        <= i_action;
            r_write_value   <= i_write_value;
            r_address_value <= i_address_value;
            r_cpu_halted    <= i_cpu_halted;
        end
    end

    vbdma_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (w_fire),
        .i_action        (r_action),
        .i_write_value   (r_write_value),
        .i_address_value (r_address_value),
        .i_cpu_halted    (r_cpu_halted),
        .o_result        (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_read_data   = r_out.read_data;
    assign o_copy_source = r_out.copy_source;
    assign o_copy_dest   = r_out.copy_dest;
    assign o_copy_blocks = r_out.copy_blocks;
    assign o_stall_dots  = r_out.stall_dots;
    assign o_active_now  = r_out.active_now;

    // no copy means no addresses and no stall reported
    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_copy_blocks == 8'd0) |->
        (o_copy_source == 16'd0 && o_copy_dest == 14'd0 && o_stall_dots == 13'd0))
        else $error("empty burst reports nonzero fields");

    // multi-block bursts come only from general mode, which never stays armed
    a_burst_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_copy_blocks > 8'd1) |-> !o_active_now)
        else $error("general burst left transfer armed");

    // input side only stalls when an item is held in the input register
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid))
        else $error("input stalled with nothing held");

    // a held result is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");

endmodule

// ===== sim/vbdma_burst_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vbdma_burst_checker
// Watches both channels of the VRAM block DMA controller. Each accepted item
// runs through a cycle-free model of the transfer state. The burst it
// predicts is queued and compared field by field with the next result.
// ----------------------------------------------------------------------------
module vbdma_burst_checker import vbdma_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_write_value,
    input  logic [15:0] i_address_value,
    input  logic        i_cpu_halted,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_read_data,
    input  logic [15:0] i_copy_source,
    input  logic [13:0] i_copy_dest,
    input  logic [7:0]  i_copy_blocks,
    input  logic [12:0] i_stall_dots,
    input  logic        i_active_now,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_checked,
    output int          o_blocks_moved
);

    localparam int MAX_PRINTED = 40;

    // transfer state as the controller should hold it
    logic [15:0] src_addr;
    logic [15:0] dst_off;
    logic [11:0] len_left;
    logic        armed;

    t_result burst_queue[$];

    task automatic report_mismatch(input string what);
        if (o_mismatches < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, what);
        o_mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                      o_checked, name, got, want));
    endtask

    // whole blocks that still fit below the end of video memory
    function automatic int vram_room_blocks();
        if (int'(dst_off) + int'(BLOCK_BYTES) > VRAM_BYTES)
            return 0;
        return (VRAM_BYTES - int'(dst_off)) / int'(BLOCK_BYTES);
    endfunction

    function automatic void move_blocks(input int n);
        src_addr = 16'(int'(src_addr) + n * int'(BLOCK_BYTES));
        dst_off  = 16'(int'(dst_off) + n * int'(BLOCK_BYTES));
        len_left = 12'(int'(len_left) - n * int'(BLOCK_BYTES));
    endfunction

    function automatic t_result predict_burst(input logic [2:0] act, input logic [7:0] val,
                                              input logic [15:0] addr, input logic halted);
        t_result     r;
        int          nblk;
        int          want;
        int          room;
        logic [15:0] src0;
        logic [15:0] dst0;
        nblk = 0;
        src0 = src_addr;
        dst0 = dst_off;
        case (act)
            ACT_CONTROL: begin
                if (armed && !val[7]) begin
                    armed = 1'b0;       // cancel keeps everything else
                end else begin
                    len_left = 12'((int'(val & LEN_MASK) + 1) * int'(BLOCK_BYTES));
                    if (val[7]) begin
                        armed = 1'b1;
                    end else begin
                        want = int'(len_left) / int'(BLOCK_BYTES);
                        room = vram_room_blocks();
                        nblk = (want < room) ? want : room;
                        move_blocks(nblk);
                        armed = 1'b0;
                    end
                end
            end
            ACT_HBLANK: begin
                if (armed && !halted) begin
                    if (vram_room_blocks() == 0) begin
                        armed = 1'b0;
                    end else begin
                        nblk = 1;
                        move_blocks(1);
                        if (len_left == 0)
                            armed = 1'b0;
                    end
                end
            end
            ACT_LOAD_SRC: src_addr = addr;
            ACT_LOAD_DST: dst_off = addr;
            default: ;
        endcase
        r.read_data   = (armed ? 8'h00 : STATUS_IDLE)
                      | 8'((int'(len_left >> BLOCK_SHIFT) - 1) & int'(LEN_MASK));
        r.copy_source = (nblk != 0) ? src0 : 16'h0;
        r.copy_dest   = (nblk != 0) ? dst0[13:0] : 14'h0;
        r.copy_blocks = 8'(nblk);
        r.stall_dots  = 13'(nblk << STALL_SHIFT);
        r.active_now  = armed;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            src_addr = '0;
            dst_off  = '0;
            len_left = '0;
            armed    = 1'b0;
            burst_queue.delete();
            o_pending = 0;
        end else begin
            if (i_in_valid && !i_in_stall)
                burst_queue.push_back(predict_burst(i_action, i_write_value,
                                                    i_address_value, i_cpu_halted));
            if (i_out_valid && !i_out_stall) begin
                if (burst_queue.size() == 0) begin
                    report_mismatch("result arrived with nothing expected");
                end else begin
                    want = burst_queue.pop_front();
                    check_field("read_data", i_read_data, want.read_data);
                    check_field("copy_source", i_copy_source, want.copy_source);
                    check_field("copy_dest", i_copy_dest, want.copy_dest);
                    check_field("copy_blocks", i_copy_blocks, want.copy_blocks);
                    check_field("stall_dots", i_stall_dots, want.stall_dots);
                    check_field("active_now", i_active_now, want.active_now);
                    o_checked++;
                    o_blocks_moved += int'(want.copy_blocks);
                end
            end
            o_pending = burst_queue.size();
        end
    end

endmodule

// ===== sim/vram_block_dma_controller_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vram_block_dma_controller_test
// Drives register loads, control writes, status reads and hblank events into
// the DMA controller with random gaps and output stalls, including one long
// output hold-off. A checker beside the block predicts every burst.
// ----------------------------------------------------------------------------
module vram_block_dma_controller_test;
    import vbdma_pkg::*;

    localparam int          RANDOM_ITEMS    = 1600;
    localparam int          CALM_FROM       = 600;
    localparam int          CALM_TO         = 900;
    localparam int          HOLD_OFF_CYCLES = 80;
    localparam int          WATCHDOG_LIMIT  = 3000;
    localparam int          DRAIN_CYCLES    = 8;
    localparam logic [7:0]  CTRL_HBLANK     = 8'h80;    // control bit 7: hblank mode

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic [2:0]  i_action        = ACT_STATUS;
    logic [7:0]  i_write_value   = '0;
    logic [15:0] i_address_value = '0;
    logic        i_cpu_halted    = 1'b0;
    logic        i_stall         = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_read_data;
    logic [15:0] o_copy_source;
    logic [13:0] o_copy_dest;
    logic [7:0]  o_copy_blocks;
    logic [12:0] o_stall_dots;
    logic        o_active_now;

    int mismatches;
    int pending;
    int checked;
    int blocks_moved;

    bit calm         = 1'b0;    // no idling on either side
    bit hold_off_req = 1'b0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int items_sent   = 0;

    always #4 i_clk = ~i_clk;

    vram_block_dma_controller i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_action        (i_action),
        .i_write_value   (i_write_value),
        .i_address_value (i_address_value),
        .i_cpu_halted    (i_cpu_halted),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_read_data     (o_read_data),
        .o_copy_source   (o_copy_source),
        .o_copy_dest     (o_copy_dest),
        .o_copy_blocks   (o_copy_blocks),
        .o_stall_dots    (o_stall_dots),
        .o_active_now    (o_active_now)
    );

    vbdma_burst_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_action        (i_action),
        .i_write_value   (i_write_value),
        .i_address_value (i_address_value),
        .i_cpu_halted    (i_cpu_halted),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_read_data     (o_read_data),
        .i_copy_source   (o_copy_source),
        .i_copy_dest     (o_copy_dest),
        .i_copy_blocks   (o_copy_blocks),
        .i_stall_dots    (o_stall_dots),
        .i_active_now    (o_active_now),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_blocks_moved  (blocks_moved)
    );

    // result side: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left = HOLD_OFF_CYCLES - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !calm && ($urandom_range(99) < 34);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("** vram_block_dma_controller: FAILED **");
                $finish;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic [2:0] act, input logic [7:0] val,
                             input logic [15:0] addr, input logic halted);
        while (!calm && $urandom_range(99) < 34) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_action        <= act;
        i_write_value   <= val;
        i_address_value <= addr;
        i_cpu_halted    <= halted;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    initial begin
        logic [15:0] src;
        logic [15:0] dst;
        logic [6:0]  len;
        logic        arm;
        int          pick;
        int          base;
        int          directed;
        bit          calm_done;
        calm_done = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset status, wraps, end of video memory, arm/cancel/rearm
        send_item(ACT_STATUS, 8'h00, 16'h0000, 1'b0);
        send_item(ACT_HBLANK, 8'hFF, 16'hFFFF, 1'b0);           // not armed
        send_item(ACT_LOAD_SRC, 8'h00, 16'hFFF0, 1'b0);
        send_item(ACT_LOAD_DST, 8'h00, 16'h0000, 1'b1);
        send_item(ACT_CONTROL, 8'h01, 16'h0000, 1'b0);          // source wraps
        send_item(ACT_LOAD_DST, 8'h00, 16'(VRAM_BYTES - 128 * 16), 1'b0);
        send_item(ACT_CONTROL, LEN_MASK, 16'h0000, 1'b0);       // longest burst
        send_item(ACT_LOAD_DST, 8'h00, 16'(VRAM_BYTES - 32), 1'b0);
        send_item(ACT_CONTROL, 8'h05, 16'h0000, 1'b0);          // cut at end
        send_item(ACT_STATUS, 8'h00, 16'h0000, 1'b0);
        send_item(ACT_LOAD_DST, 8'h00, 16'(VRAM_BYTES - 8), 1'b0);
        send_item(ACT_CONTROL, CTRL_HBLANK | 8'h02, 16'h0000, 1'b0);
        send_item(ACT_HBLANK, 8'h00, 16'h0000, 1'b0);           // no room: disarm
        send_item(ACT_LOAD_DST, 8'h00, 16'h0100, 1'b0);
        send_item(ACT_CONTROL, CTRL_HBLANK | 8'h01, 16'h0000, 1'b0);
        send_item(ACT_HBLANK, 8'h00, 16'h0000, 1'b1);           // halted
        send_item(ACT_HBLANK, 8'h00, 16'h0000, 1'b0);
        send_item(ACT_HBLANK, 8'h00, 16'h0000, 1'b0);           // length used up
        send_item(ACT_CONTROL, 8'hFF, 16'h0000, 1'b0);
        send_item(ACT_CONTROL, CTRL_HBLANK | 8'h03, 16'h0000, 1'b0);    // rearm
        send_item(ACT_HBLANK, 8'h00, 16'h0000, 1'b0);
        send_item(ACT_CONTROL, LEN_MASK, 16'h0000, 1'b0);       // cancel
        send_item(ACT_LOAD_SRC, 8'hFF, 16'hFFFF, 1'b1);
        send_item(ACT_LOAD_DST, 8'hFF, 16'hFFFF, 1'b1);
        send_item(ACT_CONTROL, 8'h00, 16'hFFFF, 1'b1);          // past the end
        for (int k = 1; k <= 3; k++)
            send_item(3'(ACT_LOAD_DST) + 3'(k), 8'hFF, 16'hFFFF, 1'b1);
        directed = items_sent;
        base = items_sent;

        // random transfers: load addresses, start, then events and noise
        while (items_sent - base < RANDOM_ITEMS) begin
            if (!calm && !calm_done && items_sent - base >= CALM_FROM) begin
                calm = 1'b1;
                hold_off_req = 1'b1;
            end
            if (calm && items_sent - base >= CALM_TO) begin
                calm = 1'b0;
                calm_done = 1'b1;
            end

            pick = $urandom_range(99);
            if (pick < 45)
                dst = 16'($urandom_range(0, VRAM_BYTES / 16 - 1) * 16);
            else if (pick < 80)
                dst = 16'(VRAM_BYTES - $urandom_range(1, 24) * 16
                          + (($urandom_range(3) == 0) ? $urandom_range(15) : 0));
            else
                dst = 16'($urandom);
            src = ($urandom_range(3) == 0) ? 16'(16'hFFFF - $urandom_range(255))
                                           : 16'($urandom);
            if ($urandom_range(3) != 0)
                send_item(ACT_LOAD_SRC, 8'($urandom), src, 1'($urandom));
            if ($urandom_range(4) != 0)
                send_item(ACT_LOAD_DST, 8'($urandom), dst, 1'($urandom));
            len = ($urandom_range(9) < 7) ? 7'($urandom_range(7)) : 7'($urandom);
            arm = ($urandom_range(9) < 6);
            send_item(ACT_CONTROL, {arm, len}, 16'($urandom), 1'($urandom));

            repeat ($urandom_range(1, 12)) begin
                pick = $urandom_range(99);
                if (pick < 60)
                    send_item(ACT_HBLANK, 8'($urandom), 16'($urandom),
                              $urandom_range(99) < 15);
                else if (pick < 75)
                    send_item(ACT_STATUS, 8'($urandom), 16'($urandom), 1'($urandom));
                else if (pick < 85)     // cancel, rearm or general burst
                    send_item(ACT_CONTROL, 8'($urandom), 16'($urandom), 1'($urandom));
                else if (pick < 92)
                    send_item($urandom_range(1) ? ACT_LOAD_SRC : ACT_LOAD_DST,
                              8'($urandom), 16'($urandom), 1'($urandom));
                else
                    send_item(3'(ACT_LOAD_DST) + 3'($urandom_range(1, 3)),
                              8'($urandom), 16'($urandom), 1'($urandom));
            end
        end
        i_valid <= 1'b0;

        do
            @(negedge i_clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items (%0d directed); compared %0d results, %0d blocks moved.",
                 items_sent, directed, checked, blocks_moved);
        $display("Covered random gaps and stalls, a %0d-cycle output hold-off and a gap-free run.",
                 HOLD_OFF_CYCLES);
        if (mismatches == 0)
            $display("** vram_block_dma_controller: PASSED **");
        else
            $display("** vram_block_dma_controller: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/vbdma_pkg.sv
rtl/vbdma_core.sv
rtl/vram_block_dma_controller.sv
sim/vbdma_burst_checker.sv
sim/vram_block_dma_controller_test.sv
